FILE: src/pfda_pkg.sv
// pfda_pkg: shared types, constants and the microcode program of the PID core.
// No dependencies; all core files but pfda_stream_if use it by scoped names.

package pfda_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FILT_BITS = 16;
  localparam int unsigned COEF_W    = 17;
  localparam int unsigned PC_W      = 4;

  localparam logic [COEF_W-1:0] FILT_ONE = COEF_W'(1 << FILT_BITS);

  localparam logic signed [DATA_W-1:0] INTEG_UPPER_RST = 32'sd4587520;
  localparam logic signed [DATA_W-1:0] INTEG_LOWER_RST = -32'sd4587520;
  localparam logic signed [DATA_W-1:0] DRIVE_UPPER_RST = 32'sd6553600;
  localparam logic signed [DATA_W-1:0] DRIVE_LOWER_RST = -32'sd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_FILT_COEFF  = 3'd3,
    CFG_INTEG_UPPER = 3'd4,
    CFG_INTEG_LOWER = 3'd5,
    CFG_DRIVE_UPPER = 3'd6,
    CFG_DRIVE_LOWER = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_RUN   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain_half_period;
    logic signed [DATA_W-1:0] deriv_gain_per_period;
    logic        [COEF_W-1:0] filter_coeff;
    logic signed [DATA_W-1:0] integ_upper;
    logic signed [DATA_W-1:0] integ_lower;
    logic signed [DATA_W-1:0] drive_upper;
    logic signed [DATA_W-1:0] drive_lower;
  } cfg_t;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_out;
  } out_item_t;

  // Multiplier A operand; B follows from it (error for kp, diff register otherwise)
  typedef enum logic [1:0] {
    MA_KP   = 2'd0,
    MA_KI   = 2'd1,
    MA_KD   = 2'd2,
    MA_COEF = 2'd3
  } mul_a_e;

  typedef enum logic [1:0] {
    DF_HOLD  = 2'd0,
    DF_FILT  = 2'd1,
    DF_ESUM  = 2'd2,
    DF_DERIV = 2'd3
  } diff_e;

  typedef enum logic [2:0] {
    AC_HOLD          = 3'd0,
    AC_LOAD_MS       = 3'd1,
    AC_ADD_RAW       = 3'd2,
    AC_LOAD_INT_TERM = 3'd3,
    AC_LOAD_TERM     = 3'd4,
    AC_ADD_UI        = 3'd5,
    AC_SUB_TERM      = 3'd6
  } acc_e;

  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_RUN   = 2'd1,
    EM_CLEAR = 2'd2
  } emit_e;

  typedef enum logic {
    JC_NEXT  = 1'b0,
    JC_CLEAR = 1'b1
  } jmp_e;

  typedef struct packed {
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            last;
    logic            wait_out;
    logic            mul_en;
    mul_a_e          mul_a;
    diff_e           diff;
    acc_e            acc;
    logic            err_ld;
    logic            yf_ld;
    logic            ui_ld;
    emit_e           emit;
  } uword_t;

  typedef struct packed {
    logic   load_in;
    logic   step_en;
    uword_t uw;
  } ctl_t;

  typedef struct packed {
    logic op_clear;
  } sts_t;

  localparam logic [PC_W-1:0] PC_CLEAR = 4'd8;

  // Control store. Products issued at step n are consumed at step n+1.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      4'd0: begin
        w.err_ld = 1'b1;
        w.diff   = DF_FILT;
        w.acc    = AC_LOAD_MS;
        w.jmp    = JC_CLEAR;
        w.target = PC_CLEAR;
      end
      4'd1: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_COEF;
        w.diff   = DF_ESUM;
      end
      4'd2: begin
        w.acc    = AC_ADD_RAW;
        w.mul_en = 1'b1;
        w.mul_a  = MA_KI;
      end
      4'd3: begin
        w.yf_ld  = 1'b1;
        w.acc    = AC_LOAD_INT_TERM;
        w.mul_en = 1'b1;
        w.mul_a  = MA_KP;
      end
      4'd4: begin
        w.ui_ld = 1'b1;
        w.acc   = AC_LOAD_TERM;
        w.diff  = DF_DERIV;
      end
      4'd5: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_KD;
        w.acc    = AC_ADD_UI;
      end
      4'd6: begin
        w.acc = AC_SUB_TERM;
      end
      4'd7: begin
        w.emit     = EM_RUN;
        w.wait_out = 1'b1;
        w.last     = 1'b1;
      end
      PC_CLEAR: begin
        w.emit     = EM_CLEAR;
        w.wait_out = 1'b1;
        w.last     = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/pfda_stream_if.sv
// pfda_stream_if: valid/ready channel carrying one item of a chosen payload type.
// Depends on nothing; payload types come from pfda_pkg at instantiation.

interface pfda_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/pfda_cfg_regs.sv
// pfda_cfg_regs: configuration register file written through a plain write port.
// Depends on pfda_pkg for the register indexes, reset values and cfg_t.

module pfda_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfda_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfda_pkg::DATA_W-1:0]       cfg_data_i,
  output pfda_pkg::cfg_t                    cfg_o
);

  pfda_pkg::cfg_t cfg_q;
  pfda_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pfda_pkg::cfg_idx_e'(cfg_idx_i))
        pfda_pkg::CFG_PROP_GAIN:   cfg_d.prop_gain              = cfg_data_i;
        pfda_pkg::CFG_INTEG_GAIN:  cfg_d.integ_gain_half_period = cfg_data_i;
        pfda_pkg::CFG_DERIV_GAIN:  cfg_d.deriv_gain_per_period  = cfg_data_i;
        pfda_pkg::CFG_FILT_COEFF:  cfg_d.filter_coeff = cfg_data_i[pfda_pkg::COEF_W-1:0];
        pfda_pkg::CFG_INTEG_UPPER: cfg_d.integ_upper            = cfg_data_i;
        pfda_pkg::CFG_INTEG_LOWER: cfg_d.integ_lower            = cfg_data_i;
        pfda_pkg::CFG_DRIVE_UPPER: cfg_d.drive_upper            = cfg_data_i;
        pfda_pkg::CFG_DRIVE_LOWER: cfg_d.drive_lower            = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain              <= '0;
      cfg_q.integ_gain_half_period <= '0;
      cfg_q.deriv_gain_per_period  <= '0;
      cfg_q.filter_coeff           <= '0;
      cfg_q.integ_upper            <= pfda_pkg::INTEG_UPPER_RST;
      cfg_q.integ_lower            <= pfda_pkg::INTEG_LOWER_RST;
      cfg_q.drive_upper            <= pfda_pkg::DRIVE_UPPER_RST;
      cfg_q.drive_lower            <= pfda_pkg::DRIVE_LOWER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/pfda_ucode_seq.sv
// pfda_ucode_seq: step counter over the microcode store, handshakes and output valid.
// Depends on pfda_pkg for the control word, its decoder and ctl_t/sts_t.

module pfda_ucode_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pfda_pkg::sts_t sts_i,
  output pfda_pkg::ctl_t ctl_o
);

  logic                      busy_q, busy_d;
  logic [pfda_pkg::PC_W-1:0] pc_q, pc_d;
  logic                      out_valid_q, out_valid_d;
  pfda_pkg::uword_t          uw;
  logic                      stall;
  logic                      accept;
  logic                      step;

  always_comb begin
    uw     = pfda_pkg::ucode(pc_q);
    // hold the emit step while the previous result is still unclaimed
    stall  = uw.wait_out && out_valid_q && !out_ready_i;
    accept = in_valid_i && !busy_q;
    step   = busy_q && !stall;

    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end
    if (step) begin
      if (uw.emit != pfda_pkg::EM_NONE) begin
        out_valid_d = 1'b1;
      end
      if (uw.last) begin
        busy_d = 1'b0;
      end else if (uw.jmp == pfda_pkg::JC_CLEAR && sts_i.op_clear) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = !busy_q;
  assign out_valid_o   = out_valid_q;
  assign ctl_o.load_in = accept;
  assign ctl_o.step_en = step;
  assign ctl_o.uw      = uw;

endmodule

FILE: src/pfda_datapath.sv
// pfda_datapath: shared magnitude multiplier, accumulator, clamps and controller state.
// Depends on pfda_pkg; driven step by step by the control word of pfda_ucode_seq.

module pfda_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfda_pkg::ctl_t      ctl_i,
  input  pfda_pkg::cfg_t      cfg_i,
  input  pfda_pkg::in_item_t  in_item_i,
  output pfda_pkg::sts_t      sts_o,
  output pfda_pkg::out_item_t out_item_o
);

  localparam int unsigned W  = pfda_pkg::DATA_W;
  localparam int unsigned AW = 2 * W;

  // captured item
  logic                op_q;
  logic signed [W-1:0] sp_q;
  logic signed [W-1:0] ms_q;

  // controller state
  logic signed [W-1:0] prev_err_q;
  logic signed [W-1:0] integ_q;
  logic signed [W-1:0] pf_q;

  // working registers
  logic signed [W-1:0]  err_q, err_d;
  logic signed [W:0]    diff_q, diff_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [W-1:0]  yf_q, yf_d;
  logic signed [W-1:0]  ui_q, ui_d;
  logic [AW-1:0]        prod_q, prod_d;
  logic                 neg_q, neg_d;

  logic signed [W-1:0] drive_q, err_out_q;

  logic signed [W:0]      e_wide;
  logic [pfda_pkg::COEF_W-1:0] coef_sat;
  logic signed [W-1:0]    a_val;
  logic                   a_neg;
  logic [W-1:0]           a_mag;
  logic                   b_neg;
  logic [W:0]             b_mag;
  logic [AW:0]            prod_full;
  logic [AW-1:0]          shifted;
  logic signed [AW-1:0]   term;
  logic signed [AW-1:0]   raw;
  logic signed [AW-1:0]   yf_sum;
  logic signed [W-1:0]    drive_clamped;

  function automatic logic signed [W-1:0] clamp_w(
    input logic signed [AW-1:0] v,
    input logic signed [W-1:0]  hi,
    input logic signed [W-1:0]  lo
  );
    logic signed [W-1:0] r;
    if (v > AW'(hi)) begin
      r = hi;
    end else if (v < AW'(lo)) begin
      r = lo;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    // saturating error
    e_wide = (W+1)'(sp_q) - (W+1)'(ms_q);
    if (e_wide[W] != e_wide[W-1]) begin
      err_d = e_wide[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      err_d = e_wide[W-1:0];
    end

    case (ctl_i.uw.diff)
      pfda_pkg::DF_FILT:  diff_d = (W+1)'(pf_q) - (W+1)'(ms_q);
      pfda_pkg::DF_ESUM:  diff_d = (W+1)'(err_q) + (W+1)'(prev_err_q);
      pfda_pkg::DF_DERIV: diff_d = (W+1)'(yf_q) - (W+1)'(pf_q);
      default:            diff_d = diff_q;
    endcase

    // sign-magnitude operands for the shared multiplier
    coef_sat = (cfg_i.filter_coeff > pfda_pkg::FILT_ONE) ? pfda_pkg::FILT_ONE
                                                         : cfg_i.filter_coeff;
    case (ctl_i.uw.mul_a)
      pfda_pkg::MA_KP: a_val = cfg_i.prop_gain;
      pfda_pkg::MA_KI: a_val = cfg_i.integ_gain_half_period;
      pfda_pkg::MA_KD: a_val = cfg_i.deriv_gain_per_period;
      default:         a_val = '0;
    endcase
    if (ctl_i.uw.mul_a == pfda_pkg::MA_COEF) begin
      a_neg = 1'b0;
      a_mag = W'(coef_sat);
    end else begin
      a_neg = a_val[W-1];
      a_mag = a_neg ? W'(-a_val) : W'(a_val);
    end
    if (ctl_i.uw.mul_a == pfda_pkg::MA_KP) begin
      b_neg = err_q[W-1];
      // zero-extend so the most negative error keeps its magnitude
      b_mag = {1'b0, (b_neg ? W'(-err_q) : W'(err_q))};
    end else begin
      b_neg = diff_q[W];
      b_mag = b_neg ? (W+1)'(-diff_q) : (W+1)'(diff_q);
    end
    prod_full = (AW+1)'(a_mag) * (AW+1)'(b_mag);
    prod_d    = prod_full[AW-1:0];
    neg_d     = a_neg ^ b_neg;

    // gain products truncate toward zero after the fraction shift
    shifted = prod_q >> FRAC_BITS;
    term    = neg_q ? -$signed(shifted) : $signed(shifted);
    raw     = neg_q ? -$signed(prod_q) : $signed(prod_q);

    case (ctl_i.uw.acc)
      pfda_pkg::AC_LOAD_MS:       acc_d = AW'(ms_q) <<< pfda_pkg::FILT_BITS;
      pfda_pkg::AC_ADD_RAW:       acc_d = acc_q + raw;
      pfda_pkg::AC_LOAD_INT_TERM: acc_d = AW'(integ_q) + term;
      pfda_pkg::AC_LOAD_TERM:     acc_d = term;
      pfda_pkg::AC_ADD_UI:        acc_d = acc_q + AW'(ui_q);
      pfda_pkg::AC_SUB_TERM:      acc_d = acc_q - term;
      default:                    acc_d = acc_q;
    endcase

    // filter output: bias negative values so the arithmetic shift truncates toward zero
    yf_sum = acc_q + (acc_q[AW-1] ? AW'((1 << pfda_pkg::FILT_BITS) - 1) : '0);
    yf_d   = yf_sum[pfda_pkg::FILT_BITS+W-1:pfda_pkg::FILT_BITS];

    ui_d          = clamp_w(acc_q, cfg_i.integ_upper, cfg_i.integ_lower);
    drive_clamped = clamp_w(acc_q, cfg_i.drive_upper, cfg_i.drive_lower);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      op_q <= in_item_i.op;
      sp_q <= in_item_i.setpoint;
      ms_q <= in_item_i.measured;
    end
    if (ctl_i.step_en) begin
      if (ctl_i.uw.err_ld) err_q <= err_d;
      diff_q <= diff_d;
      acc_q  <= acc_d;
      if (ctl_i.uw.yf_ld) yf_q <= yf_d;
      if (ctl_i.uw.ui_ld) ui_q <= ui_d;
      if (ctl_i.uw.mul_en) begin
        prod_q <= prod_d;
        neg_q  <= neg_d;
      end
      case (ctl_i.uw.emit)
        pfda_pkg::EM_RUN: begin
          drive_q   <= drive_clamped;
          err_out_q <= err_q;
        end
        pfda_pkg::EM_CLEAR: begin
          drive_q   <= '0;
          err_out_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      pf_q       <= '0;
    end else if (ctl_i.step_en) begin
      case (ctl_i.uw.emit)
        pfda_pkg::EM_RUN: begin
          prev_err_q <= err_q;
          integ_q    <= ui_q;
          pf_q       <= yf_q;
        end
        pfda_pkg::EM_CLEAR: begin
          prev_err_q <= '0;
          integ_q    <= '0;
          pf_q       <= '0;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.op_clear       = (op_q == pfda_pkg::OP_CLEAR);
  assign out_item_o.drive     = drive_q;
  assign out_item_o.error_out = err_out_q;

endmodule

FILE: src/pid_filtered_derivative_antiwindup_core.sv
// Channel  | Dir | Payload                           | Handshake
// in_if    | in  | op, setpoint, measured (Q16.16)   | valid/ready, taken on valid & ready
// out_if   | out | drive, error_out (Q16.16)         | valid/ready, taken on valid & ready
// cfg      | in  | cfg_idx_i, cfg_data_i             | write on cfg_we_i, no stall
//
// A run item passes the accept edge and eight microcode steps, four of which feed the
// single shared 32x33 magnitude multiplier; a new item waits for the last step. A clear
// item runs step 0, then the clear step. The emit step holds while the output register
// is full, so a new item is taken while the previous result still waits downstream.
// Reset clears configuration to its defaults and the controller state to zero.
//
// Top level of the PID core; depends on pfda_pkg, pfda_stream_if, pfda_cfg_regs,
// pfda_ucode_seq and pfda_datapath.

module pid_filtered_derivative_antiwindup_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfda_pkg::DATA_W-1:0]    cfg_data_i,
  pfda_stream_if.sink                    in_if,
  pfda_stream_if.source                  out_if
);

  pfda_pkg::cfg_t      cfg;
  pfda_pkg::ctl_t      ctl;
  pfda_pkg::sts_t      sts;
  pfda_pkg::out_item_t out_item;

  pfda_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pfda_ucode_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pfda_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cfg_i      (cfg),
    .in_item_i  (in_if.payload),
    .sts_o      (sts),
    .out_item_o (out_item)
  );

  assign out_if.payload = out_item;

endmodule

FILE: src/pfda_checker.sv
// pfda_checker: port-level assertions on the PID core, attached by bind below.
// Depends on pfda_pkg for the result item type.

module pfda_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input pfda_pkg::out_item_t out_payload_i
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in progress");

  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in progress");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("result appeared too soon after accept");

endmodule

bind pid_filtered_derivative_antiwindup_core pfda_checker u_pfda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_payload_i (out_if.payload)
);

FILE: verif/tb.sv
// tb: self-checking testbench for pid_filtered_derivative_antiwindup_core.
// Predicts every result from its own copy of the PID state and compares field by field.
// Depends on pfda_pkg, pfda_stream_if and the core itself.

module tb;
  import pfda_pkg::*;

  localparam int unsigned FRAC        = 16;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam longint      MAX32       = 64'sd2147483647;
  localparam longint      MIN32       = -64'sd2147483648;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  pfda_stream_if #(.payload_t(in_item_t))  in_if ();
  pfda_stream_if #(.payload_t(out_item_t)) out_if ();

  pid_filtered_derivative_antiwindup_core #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Controller copy: registers and state as the core should hold them
  cfg_t   model_cfg;
  longint last_err  = 0;
  longint integ_acc = 0;
  longint last_filt = 0;

  out_item_t   drive_err_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned idle_cycles    = 0;
  bit          steady         = 1'b0;
  int          plant          = 0;
  int          target         = 0;

  // Product of magnitudes, shifted, sign restored: rounds toward zero
  function automatic longint mul_trunc(longint a, longint b, int unsigned sh);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = (ma * mb) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Upper limit is tested first and wins for values above it, even with crossed limits
  function automatic longint limit(longint v, longint hi, longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic out_item_t pid_step(in_item_t it);
    longint    sp, ms, err, up, ui, wt, num, yf, ud, u;
    out_item_t res;
    if (it.op == OP_CLEAR) begin
      last_err  = 0;
      integ_acc = 0;
      last_filt = 0;
      return '0;
    end
    sp  = longint'($signed(it.setpoint));
    ms  = longint'($signed(it.measured));
    err = limit(sp - ms, MAX32, MIN32);
    up  = mul_trunc(longint'($signed(model_cfg.prop_gain)), err, FRAC);
    ui  = integ_acc +
          mul_trunc(longint'($signed(model_cfg.integ_gain_half_period)), err + last_err, FRAC);
    ui  = limit(ui, longint'($signed(model_cfg.integ_upper)),
                longint'($signed(model_cfg.integ_lower)));
    wt  = longint'(model_cfg.filter_coeff);
    if (wt > longint'(FILT_ONE)) wt = longint'(FILT_ONE);
    num = wt * last_filt + (longint'(FILT_ONE) - wt) * ms;
    yf  = mul_trunc(num, 1, FILT_BITS);
    ud  = -mul_trunc(longint'($signed(model_cfg.deriv_gain_per_period)), yf - last_filt, FRAC);
    u   = limit(up + ui + ud, longint'($signed(model_cfg.drive_upper)),
                longint'($signed(model_cfg.drive_lower)));
    last_err      = err;
    integ_acc     = ui;
    last_filt     = yf;
    res.drive     = u[31:0];
    res.error_out = err[31:0];
    return res;
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on result %0d, %s: expected %0d (%h), got %0d (%h)", result_count,
               what, $signed(want), want, $signed(got), got);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    result_count++;
    if (drive_err_q.size() == 0) begin
      note_mismatch("unexpected item", '0, got.drive);
      return;
    end
    want = drive_err_q.pop_front();
    if (got.drive !== want.drive) note_mismatch("drive", want.drive, got.drive);
    if (got.error_out !== want.error_out) note_mismatch("error_out", want.error_out, got.error_out);
  endfunction

  function automatic in_item_t mk_item(op_e op, logic [31:0] sp, logic [31:0] ms);
    in_item_t it;
    it.op       = op;
    it.setpoint = sp;
    it.measured = ms;
    return it;
  endfunction

  function automatic cfg_t make_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                         logic [COEF_W-1:0] coef, logic [31:0] iu,
                                         logic [31:0] il, logic [31:0] du, logic [31:0] dl);
    cfg_t c;
    c.prop_gain              = kp;
    c.integ_gain_half_period = ki;
    c.deriv_gain_per_period  = kd;
    c.filter_coeff           = coef;
    c.integ_upper            = iu;
    c.integ_lower            = il;
    c.drive_upper            = du;
    c.drive_lower            = dl;
    return c;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5, 6: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] pick_limits();
    int hi, lo;
    hi = int'($urandom_range(0, 32'h0100_0000));
    lo = -int'($urandom_range(0, 32'h0100_0000));
    case ($urandom_range(0, 7))
      0:       return {32'h7fff_ffff, 32'h8000_0000};
      1:       return {lo, hi};
      2:       return {$urandom(), $urandom()};
      default: return {hi, lo};
    endcase
  endfunction

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 4))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return 32'h0000_0001;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic cfg_t random_settings(int phase);
    cfg_t c;
    case (phase)
      0: c = make_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0,
                           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      1: c = make_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, FILT_ONE,
                           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      default: begin
        c.prop_gain              = pick_gain();
        c.integ_gain_half_period = pick_gain();
        c.deriv_gain_per_period  = pick_gain();
        case ($urandom_range(0, 5))
          0:       c.filter_coeff = '0;
          1:       c.filter_coeff = FILT_ONE;
          2:       c.filter_coeff = COEF_W'($urandom_range(32'h1_0001, 32'h1_ffff));
          default: c.filter_coeff = COEF_W'($urandom_range(0, 32'h0_ffff));
        endcase
        {c.integ_upper, c.integ_lower} = pick_limits();
        {c.drive_upper, c.drive_lower} = pick_limits();
      end
    endcase
    return c;
  endfunction

  // Mostly a measurement tracking a setpoint, plus clears, noise and extremes
  function automatic in_item_t next_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it = mk_item(OP_CLEAR, $urandom(), $urandom());
    end else if (r < 12) begin
      it = mk_item(OP_RUN, $urandom(), $urandom());
    end else if (r < 16) begin
      it = mk_item(OP_RUN, pick_edge(), pick_edge());
    end else begin
      if ($urandom_range(0, 19) == 0)
        target = int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      plant = plant + (target - plant) / 8 + int'($urandom_range(0, 8192)) - 4096;
      it = mk_item(OP_RUN, target, plant);
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    drive_err_q.push_back(pid_step(it));
  endtask

  task automatic run_item(logic [31:0] sp, logic [31:0] ms);
    send_item(mk_item(OP_RUN, sp, ms));
  endtask

  // Drop valid, wait for every pending result, then let the core go quiet
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (drive_err_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_PROP_GAIN:   model_cfg.prop_gain              = value;
      CFG_INTEG_GAIN:  model_cfg.integ_gain_half_period = value;
      CFG_DERIV_GAIN:  model_cfg.deriv_gain_per_period  = value;
      CFG_FILT_COEFF:  model_cfg.filter_coeff           = value[COEF_W-1:0];
      CFG_INTEG_UPPER: model_cfg.integ_upper            = value;
      CFG_INTEG_LOWER: model_cfg.integ_lower            = value;
      CFG_DRIVE_UPPER: model_cfg.drive_upper            = value;
      CFG_DRIVE_LOWER: model_cfg.drive_lower            = value;
      default: ;
    endcase
  endtask

  task automatic change_settings(cfg_t c);
    settle_idle();
    write_reg(CFG_PROP_GAIN, c.prop_gain);
    write_reg(CFG_INTEG_GAIN, c.integ_gain_half_period);
    write_reg(CFG_DERIV_GAIN, c.deriv_gain_per_period);
    // upper data bits of the weight are junk and must be ignored
    write_reg(CFG_FILT_COEFF, ($urandom() & 32'hfffe_0000) | 32'(c.filter_coeff));
    write_reg(CFG_INTEG_UPPER, c.integ_upper);
    write_reg(CFG_INTEG_LOWER, c.integ_lower);
    write_reg(CFG_DRIVE_UPPER, c.drive_upper);
    write_reg(CFG_DRIVE_LOWER, c.drive_lower);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_values();
    run_item('0, '0);
    run_item(32'h0001_0000, 32'h0003_0000);
    send_item(mk_item(OP_CLEAR, 32'h0001_0000, 32'h0002_0000));
  endtask

  task automatic test_error_saturation();
    change_settings(make_settings(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 17'h0_8000,
                                  INTEG_UPPER_RST, INTEG_LOWER_RST,
                                  DRIVE_UPPER_RST, DRIVE_LOWER_RST));
    run_item(32'h7fff_ffff, 32'h8000_0000);
    run_item(32'h8000_0000, 32'h7fff_ffff);
    run_item(32'h7fff_ffff, 32'h7fff_ffff);
    run_item(32'h8000_0000, 32'h0000_0001);
  endtask

  task automatic test_integrator_clamp();
    change_settings(make_settings('0, 32'h0002_0000, '0, '0, 32'h0005_0000, -32'sh0005_0000,
                                  DRIVE_UPPER_RST, DRIVE_LOWER_RST));
    run_item(32'h0003_0000, '0);
    run_item(32'h0003_0000, '0);
    run_item(-32'sh0003_0000, '0);
    run_item(-32'sh0003_0000, '0);
  endtask

  task automatic test_filter_weight();
    // weight above one freezes the filtered value, so no derivative kick
    change_settings(make_settings('0, '0, 32'h7fff_ffff, 17'h1_ffff,
                                  INTEG_UPPER_RST, INTEG_LOWER_RST,
                                  DRIVE_UPPER_RST, DRIVE_LOWER_RST));
    run_item('0, 32'h0010_0000);
    run_item('0, -32'sh0010_0000);
    change_settings(make_settings('0, '0, 32'h7fff_ffff, '0,
                                  INTEG_UPPER_RST, INTEG_LOWER_RST,
                                  DRIVE_UPPER_RST, DRIVE_LOWER_RST));
    run_item('0, 32'h0010_0000);
    run_item('0, '0);
  endtask

  task automatic test_crossed_limits();
    change_settings(make_settings(32'h0001_0000, 32'h0001_0000, '0, '0,
                                  -32'sh0001_0000, 32'h0001_0000,
                                  -32'sh0002_0000, 32'h0002_0000));
    run_item(32'h0000_8000, '0);
    run_item('0, '0);
  endtask

  task automatic test_gain_extremes();
    change_settings(random_settings(1));
    run_item(32'h8000_0000, 32'h7fff_ffff);
    run_item(32'h8000_0000, 32'h7fff_ffff);
    change_settings(random_settings(0));
    run_item(32'h7fff_ffff, 32'h8000_0000);
    run_item(32'h8000_0000, 32'h7fff_ffff);
  endtask

  task automatic test_clear();
    change_settings(make_settings(32'h0001_8000, 32'h0000_4000, 32'h0002_0000, 17'h0_c000,
                                  INTEG_UPPER_RST, INTEG_LOWER_RST,
                                  DRIVE_UPPER_RST, DRIVE_LOWER_RST));
    run_item(32'h0005_0000, 32'h0001_0000);
    run_item(32'h0005_0000, 32'h0002_0000);
    send_item(mk_item(OP_CLEAR, $urandom(), $urandom()));
    run_item(32'h0005_0000, 32'h0003_0000);
    run_item(32'h0005_0000, 32'h0003_0000);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      change_settings(random_settings(phase));
      steady = (phase % 3 == 2);
      plant  = 0;
      target = 0;
      for (int n = 0; n < 104; n++) send_item(next_item());
    end
    steady = 1'b0;
  endtask

  initial begin
    model_cfg = make_settings('0, '0, '0, '0, INTEG_UPPER_RST, INTEG_LOWER_RST,
                              DRIVE_UPPER_RST, DRIVE_LOWER_RST);
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_PROP_GAIN;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_error_saturation();
    test_integrator_clamp();
    test_filter_weight();
    test_crossed_limits();
    test_gain_extremes();
    test_clear();
    test_random_phases();

    settle_idle();
    if (mismatch_count == 0 && drive_err_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      check_result(out_if.payload);
    end
  end

  // Watchdog: give up when no item moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

FILE: files.f
src/pfda_pkg.sv
src/pfda_stream_if.sv
src/pfda_cfg_regs.sv
src/pfda_ucode_seq.sv
src/pfda_datapath.sv
src/pid_filtered_derivative_antiwindup_core.sv
src/pfda_checker.sv
verif/tb.sv
